FILE: sv/gpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_pkg
// Widths, limits and result type shared by the pair force pipeline.
// ----------------------------------------------------------------------------
package gpf_pkg;

   localparam int POS_W   = 32;
   localparam int MASS_W  = 32;
   localparam int DX_W    = 32;
   localparam int RSUM_W  = 33;
   localparam int S_W     = 66;
   localparam int RT_W    = 33;
   localparam int SQ_N    = 33;
   localparam int T_W     = 68;
   localparam int GM_W    = 64;
   localparam int PROD_W  = 96;
   localparam int DEN_W   = 99;
   localparam int NUM_W   = 128;
   localparam int Q_W     = 49;
   localparam int FORCE_W = 48;

   localparam logic [MASS_W-1:0]  GRAV_RESET   = 32'd65536;
   localparam logic [FORCE_W-1:0] FORCE_POS_LIM = 48'h7FFF_FFFF_FFFF;
   localparam logic [FORCE_W-1:0] FORCE_NEG_LIM = 48'h8000_0000_0000;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_north;
      logic signed [FORCE_W-1:0] force_east;
      logic                      overlap;
      logic                      saturated;
   } rsp_type;

endpackage

FILE: sv/gpf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_if
// Request, response and register write channels of the pair force core.
// ----------------------------------------------------------------------------
interface gpf_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [gpf_pkg::POS_W-1:0] pos_a_x;
   logic signed [gpf_pkg::POS_W-1:0] pos_a_y;
   logic signed [gpf_pkg::POS_W-1:0] pos_b_x;
   logic signed [gpf_pkg::POS_W-1:0] pos_b_y;
   logic [gpf_pkg::MASS_W-1:0]       mass_a;
   logic [gpf_pkg::MASS_W-1:0]       mass_b;
   logic [gpf_pkg::MASS_W-1:0]       radius_a;
   logic [gpf_pkg::MASS_W-1:0]       radius_b;
   modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b,
                   radius_a, radius_b, input ready);
   modport sink (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b,
                 radius_a, radius_b, output ready);
endinterface

interface gpf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [gpf_pkg::FORCE_W-1:0] force_north;
   logic signed [gpf_pkg::FORCE_W-1:0] force_east;
   logic                               overlap;
   logic                               saturated;
   modport source (output valid, force_north, force_east, overlap, saturated, input ready);
   modport sink (input valid, force_north, force_east, overlap, saturated, output ready);
endinterface

interface gpf_csr_if;
   logic                       valid;
   logic                       ready;
   logic [gpf_pkg::MASS_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: sv/gpf_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_div_pipe
// Restoring divider, one quotient bit per stage; top bit flags overflow.
// ----------------------------------------------------------------------------
module gpf_div_pipe (
   input  logic                          clock,
   input  logic                          en,
   input  logic [gpf_pkg::NUM_W-1:0]     num,
   input  logic [gpf_pkg::DEN_W-1:0]     den,
   output logic [gpf_pkg::Q_W-1:0]       quo
);
   import gpf_pkg::*;

   logic [NUM_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int B = Q_W - 1 - k;
      logic [NUM_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [Q_W-1:0]   quo_cur;
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign rem_cur = num;
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      always_comb begin
         rem_in = rem_cur;
         quo_in = quo_cur;
         if ((rem_cur >> B) >= NUM_W'(den_cur)) begin
            rem_in = rem_cur - (NUM_W'(den_cur) << B);
            quo_in = quo_cur | (Q_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[Q_W-1];

endmodule

FILE: sv/gravity_pair_force_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_pair_force_2d_core
// Newtonian pair force in the plane, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// req_ch carries one particle pair per request: signed Q16.16 positions and
// unsigned Q16.16 masses and radii. rsp_ch returns one result per request:
// saturating signed Q32.16 force components along dx and dy, an overlap flag
// and a saturation flag. csr_ch writes the gravitational constant (Q16.16,
// 1.0 after reset); write it only while no request is in flight.
// One request is taken every cycle while the skid register is empty. A result
// passes through 3 multiply/add stages, 33 square root stages (one root
// bit each), 2 stages for the wide products, 49 divider stages (one quotient
// bit each, the first one detecting overflow) and the output register.
// Reset clears every valid bit and loads G = 1.0.
// When rsp_ch stalls, the pending result moves into a skid register and the
// whole pipeline freezes while it is full; req_ch.ready is low only then.
// ----------------------------------------------------------------------------
module gravity_pair_force_2d_core (
   input  logic       clock,
   input  logic       reset,
   gpf_req_if.sink    req_ch,
   gpf_rsp_if.source  rsp_ch,
   gpf_csr_if.sink    csr_ch
);
   import gpf_pkg::*;

   typedef struct packed {
      logic             ovl;
      logic             nx;
      logic             ny;
      logic [S_W-1:0]   s;
      logic [S_W-1:0]   sq;
      logic [RT_W-1:0]  rt;
      logic [PROD_W-1:0] prod;
      logic [DX_W-1:0]  ux;
      logic [DX_W-1:0]  uy;
   } sqs_type;

   typedef struct packed {
      logic ovl;
      logic nx;
      logic ny;
      logic zero;
   } flag_type;

   function automatic logic [FORCE_W:0] clamp(input logic [Q_W-1:0] q, input logic neg);
      logic [FORCE_W-1:0] lim;
      logic [FORCE_W-1:0] m;
      logic               over;
      lim  = neg ? FORCE_NEG_LIM : FORCE_POS_LIM;
      over = q[Q_W-1] || (q[FORCE_W-1:0] > lim);
      m    = over ? lim : q[FORCE_W-1:0];
      return {over, neg ? (FORCE_W'(0) - m) : m};
   endfunction

   logic              en;
   logic [MASS_W-1:0] grav_ff;

   // stage 1
   logic signed [DX_W:0] dx, dy;
   logic              v1_ff, nx1_ff, ny1_ff;
   logic [DX_W-1:0]   ux1_ff, uy1_ff;
   logic [RSUM_W-1:0] rsum1_ff;
   logic [GM_W-1:0]   gm1_ff;
   logic [MASS_W-1:0] mb1_ff;

   // stage 2
   logic              v2_ff, nx2_ff, ny2_ff;
   logic [DX_W-1:0]   ux2_ff, uy2_ff;
   logic [2*DX_W-1:0] sxx2_ff, syy2_ff;
   logic [S_W-1:0]    rr2_ff;
   logic [GM_W-1:0]   pl2_ff, ph2_ff;

   // stage 3 and root
   logic [S_W-1:0]    s3;
   logic              v3_ff;
   sqs_type           st3_ff;
   logic [SQ_N-1:0]   sqv_ff;
   sqs_type           sq_ff [SQ_N];
   sqs_type           rt_last;

   // stages 4 and 5
   logic              v4_ff, v5_ff;
   flag_type          fl4_ff, fl5_ff;
   logic [2*RT_W-1:0] dp0_ff, dp1_ff;
   logic [GM_W:0]     npx_ff [3];
   logic [GM_W:0]     npy_ff [3];
   logic [DEN_W-1:0]  den5_ff;
   logic [NUM_W-1:0]  numx5_ff, numy5_ff;

   // divider stages
   logic [Q_W-1:0]    flv_ff;
   flag_type          fl_ff [Q_W];
   logic [Q_W-1:0]    qx, qy;

   // output
   logic              lv_ff, sk_full_ff, sk_full_in;
   rsp_type           l_ff, l_in, sk_ff, sk_in, rsp_pay;
   logic [FORCE_W:0]  cx, cy;

   assign en            = !sk_full_ff;
   assign req_ch.ready  = en;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= GRAV_RESET;
      end else if (csr_ch.valid) begin
         grav_ff <= csr_ch.data;
      end
   end

   // differences, radius sum, G*ma
   always_comb begin
      dx = (DX_W+1)'(req_ch.pos_b_x) - (DX_W+1)'(req_ch.pos_a_x);
      dy = (DX_W+1)'(req_ch.pos_b_y) - (DX_W+1)'(req_ch.pos_a_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign s3 = S_W'(sxx2_ff) + S_W'(syy2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         nx1_ff   <= dx[DX_W];
         ny1_ff   <= dy[DX_W];
         ux1_ff   <= dx[DX_W] ? DX_W'(-dx) : dx[DX_W-1:0];
         uy1_ff   <= dy[DX_W] ? DX_W'(-dy) : dy[DX_W-1:0];
         rsum1_ff <= RSUM_W'(req_ch.radius_a) + RSUM_W'(req_ch.radius_b);
         gm1_ff   <= GM_W'(grav_ff) * GM_W'(req_ch.mass_a);
         mb1_ff   <= req_ch.mass_b;

         nx2_ff  <= nx1_ff;
         ny2_ff  <= ny1_ff;
         ux2_ff  <= ux1_ff;
         uy2_ff  <= uy1_ff;
         sxx2_ff <= (2*DX_W)'(ux1_ff) * (2*DX_W)'(ux1_ff);
         syy2_ff <= (2*DX_W)'(uy1_ff) * (2*DX_W)'(uy1_ff);
         rr2_ff  <= S_W'(rsum1_ff) * S_W'(rsum1_ff);
         pl2_ff  <= GM_W'(gm1_ff[MASS_W-1:0]) * GM_W'(mb1_ff);
         ph2_ff  <= GM_W'(gm1_ff[GM_W-1:MASS_W]) * GM_W'(mb1_ff);

         st3_ff.ovl  <= s3 < rr2_ff;
         st3_ff.nx   <= nx2_ff;
         st3_ff.ny   <= ny2_ff;
         st3_ff.s    <= s3;
         st3_ff.sq   <= '0;
         st3_ff.rt   <= '0;
         st3_ff.prod <= PROD_W'(pl2_ff) + (PROD_W'(ph2_ff) << MASS_W);
         st3_ff.ux   <= ux2_ff;
         st3_ff.uy   <= uy2_ff;
      end
   end

   // floor square root, one bit per stage, running square kept alongside
   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      localparam int B = SQ_N - 1 - j;
      sqs_type        cur;
      sqs_type        sq_in;
      logic           cur_v;
      logic [T_W-1:0] t;

      if (j == 0) begin : g_first
         assign cur   = st3_ff;
         assign cur_v = v3_ff;
      end else begin : g_next
         assign cur   = sq_ff[j-1];
         assign cur_v = sqv_ff[j-1];
      end

      always_comb begin
         t     = T_W'(cur.sq) + (T_W'(cur.rt) << (B + 1)) + (T_W'(1) << (2 * B));
         sq_in = cur;
         if (t <= T_W'(cur.s)) begin
            sq_in.rt = cur.rt | (RT_W'(1) << B);
            sq_in.sq = t[S_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[j] <= 1'b0;
         end else if (en) begin
            sqv_ff[j] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j] <= sq_in;
         end
      end
   end

   assign rt_last = sq_ff[SQ_N-1];

   // partial products of S*D and prod*|d|, then their sums
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sqv_ff[SQ_N-1];
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl4_ff.ovl  <= rt_last.ovl;
         fl4_ff.nx   <= rt_last.nx;
         fl4_ff.ny   <= rt_last.ny;
         fl4_ff.zero <= rt_last.s == '0;
         dp0_ff <= (2*RT_W)'(rt_last.s[RT_W-1:0]) * (2*RT_W)'(rt_last.rt);
         dp1_ff <= (2*RT_W)'(rt_last.s[S_W-1:RT_W]) * (2*RT_W)'(rt_last.rt);
         for (int i = 0; i < 3; i++) begin
            npx_ff[i] <= (GM_W+1)'(rt_last.prod[i*MASS_W +: MASS_W]) * (GM_W+1)'(rt_last.ux);
            npy_ff[i] <= (GM_W+1)'(rt_last.prod[i*MASS_W +: MASS_W]) * (GM_W+1)'(rt_last.uy);
         end

         fl5_ff   <= fl4_ff;
         den5_ff  <= DEN_W'(dp0_ff) + (DEN_W'(dp1_ff) << RT_W);
         numx5_ff <= NUM_W'(npx_ff[0]) + (NUM_W'(npx_ff[1]) << MASS_W)
                     + (NUM_W'(npx_ff[2]) << (2 * MASS_W));
         numy5_ff <= NUM_W'(npy_ff[0]) + (NUM_W'(npy_ff[1]) << MASS_W)
                     + (NUM_W'(npy_ff[2]) << (2 * MASS_W));
      end
   end

   gpf_div_pipe u_div_x (
      .clock (clock),
      .en    (en),
      .num   (numx5_ff),
      .den   (den5_ff),
      .quo   (qx)
   );

   gpf_div_pipe u_div_y (
      .clock (clock),
      .en    (en),
      .num   (numy5_ff),
      .den   (den5_ff),
      .quo   (qy)
   );

   // flags ride alongside the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         flv_ff <= '0;
      end else if (en) begin
         flv_ff <= {flv_ff[Q_W-2:0], v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0] <= fl5_ff;
         for (int i = 1; i < Q_W; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   // clamp, sign, special cases
   always_comb begin
      cx   = clamp(qx, fl_ff[Q_W-1].nx);
      cy   = clamp(qy, fl_ff[Q_W-1].ny);
      l_in = '0;
      if (fl_ff[Q_W-1].ovl) begin
         l_in.overlap = 1'b1;
      end else if (!fl_ff[Q_W-1].zero) begin
         l_in.force_north = cx[FORCE_W-1:0];
         l_in.force_east  = cy[FORCE_W-1:0];
         l_in.saturated   = cx[FORCE_W] | cy[FORCE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= 1'b0;
      end else if (en) begin
         lv_ff <= flv_ff[Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff <= l_in;
      end
   end

   // skid register
   always_comb begin
      sk_full_in = sk_full_ff;
      sk_in      = sk_ff;
      if (sk_full_ff) begin
         if (rsp_ch.ready) begin
            sk_full_in = 1'b0;
         end
      end else if (lv_ff && !rsp_ch.ready) begin
         sk_full_in = 1'b1;
         sk_in      = l_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_full_ff <= 1'b0;
      end else begin
         sk_full_ff <= sk_full_in;
      end
   end

   always_ff @(posedge clock) begin
      sk_ff <= sk_in;
   end

   assign rsp_pay            = sk_full_ff ? sk_ff : l_ff;
   assign rsp_ch.valid       = sk_full_ff | lv_ff;
   assign rsp_ch.force_north = rsp_pay.force_north;
   assign rsp_ch.force_east  = rsp_pay.force_east;
   assign rsp_ch.overlap     = rsp_pay.overlap;
   assign rsp_ch.saturated   = rsp_pay.saturated;

   // overlapping pairs never carry force
   a_overlap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.overlap) |->
         (rsp_ch.force_north == '0 && rsp_ch.force_east == '0 && !rsp_ch.saturated))
      else $error("overlap result carries force");

   // a clamped result sits on a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.force_north == FORCE_POS_LIM || rsp_ch.force_north == FORCE_NEG_LIM ||
          rsp_ch.force_east == FORCE_POS_LIM || rsp_ch.force_east == FORCE_NEG_LIM))
      else $error("saturated result off its limit");

   // pipeline frozen while the skid holds a result
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      sk_full_ff |=> ($stable(lv_ff) && $stable(l_ff) && $stable(flv_ff)))
      else $error("pipeline moved during stall");

   // skid only fills from a stalled output register
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_full_ff) |-> ($past(lv_ff) && !$past(rsp_ch.ready)))
      else $error("skid filled without stalled result");

endmodule

FILE: tb/gravity_pair_force_2d_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_pair_force_2d_core_tb
// Self-checking bench for the planar pair force core.
// ----------------------------------------------------------------------------
// Drives particle pairs on req_ch, predicts every force result in wide
// integer arithmetic and compares it in order with rsp_ch. Runs through
// several values of the gravitational constant and several idle and stall
// mixes, including one long response hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module gravity_pair_force_2d_core_tb;
   import gpf_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0] ax, ay, bx, by;
      logic [MASS_W-1:0]       ma, mb, ra, rb;
   } pair_type;

   class force_scoreboard;
      logic [MASS_W-1:0] grav;
      rsp_type           expected_forces[$];
      int                errors;
      int                checked;
      int                overlaps;
      int                clamps;

      function new();
         grav = GRAV_RESET;
         errors = 0;
         checked = 0;
         overlaps = 0;
         clamps = 0;
      endfunction

      function logic [FORCE_W-1:0] axis_force(logic [PROD_W-1:0] prod,
                                              logic signed [DX_W:0] d,
                                              logic [DEN_W-1:0] den,
                                              inout bit sat);
         logic [DX_W:0]        mag;
         logic [NUM_W-1:0]     num, q, lim;
         logic [FORCE_W-1:0]   m;
         mag = d[DX_W] ? -d : d;
         num = NUM_W'(prod) * NUM_W'(mag);
         q = num / NUM_W'(den);
         lim = d[DX_W] ? NUM_W'(FORCE_NEG_LIM) : NUM_W'(FORCE_POS_LIM);
         if (q > lim) begin
            m = lim[FORCE_W-1:0];
            sat = 1;
         end else begin
            m = q[FORCE_W-1:0];
         end
         return d[DX_W] ? -m : m;
      endfunction

      function rsp_type pair_force(pair_type r);
         logic signed [DX_W:0] dx, dy;
         logic [DX_W:0]        ux, uy, rsum;
         logic [S_W-1:0]       s, rsq;
         logic [RT_W:0]        root, cand;
         logic [T_W-1:0]       csq;
         logic [DEN_W-1:0]     den;
         logic [GM_W-1:0]      gm;
         logic [PROD_W-1:0]    prod;
         rsp_type              o;
         bit                   sat;
         dx = {r.bx[POS_W-1], r.bx} - {r.ax[POS_W-1], r.ax};
         dy = {r.by[POS_W-1], r.by} - {r.ay[POS_W-1], r.ay};
         ux = dx[DX_W] ? -dx : dx;
         uy = dy[DX_W] ? -dy : dy;
         s = S_W'(ux) * S_W'(ux) + S_W'(uy) * S_W'(uy);
         rsum = {1'b0, r.ra} + {1'b0, r.rb};
         rsq = S_W'(rsum) * S_W'(rsum);
         o = '0;
         sat = 0;
         if (s < rsq) begin
            o.overlap = 1;
            return o;
         end
         if (s == 0) return o;
         root = '0;
         for (int b = RT_W; b >= 0; b--) begin
            cand = root | ((RT_W+1)'(1) << b);
            csq = T_W'(cand) * T_W'(cand);
            if (T_W'(s) >= csq) root = cand;
         end
         den = DEN_W'(s) * DEN_W'(root);
         gm = GM_W'(grav) * GM_W'(r.ma);
         prod = PROD_W'(gm) * PROD_W'(r.mb);
         o.force_north = axis_force(prod, dx, den, sat);
         o.force_east = axis_force(prod, dy, den, sat);
         o.saturated = sat;
         return o;
      endfunction

      function void note_request(pair_type r);
         expected_forces.push_back(pair_force(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_forces.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         e = expected_forces.pop_front();
         checked++;
         if (e.overlap) overlaps++;
         if (e.saturated) clamps++;
         if (got.force_north !== e.force_north) begin
            $display("%0t: force_north expected %0d actual %0d", $time, e.force_north,
                     got.force_north);
            errors++;
         end
         if (got.force_east !== e.force_east) begin
            $display("%0t: force_east expected %0d actual %0d", $time, e.force_east,
                     got.force_east);
            errors++;
         end
         if (got.overlap !== e.overlap) begin
            $display("%0t: overlap expected %0b actual %0b", $time, e.overlap, got.overlap);
            errors++;
         end
         if (got.saturated !== e.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                     got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   hold_cycles = 0;
   force_scoreboard sb = new();

   gpf_req_if req_ch();
   gpf_rsp_if rsp_ch();
   gpf_csr_if csr_ch();

   gravity_pair_force_2d_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.pos_a_x = '0;
      req_ch.pos_a_y = '0;
      req_ch.pos_b_x = '0;
      req_ch.pos_b_y = '0;
      req_ch.mass_a = '0;
      req_ch.mass_b = '0;
      req_ch.radius_a = '0;
      req_ch.radius_b = '0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.data = '0;
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request('{req_ch.pos_a_x, req_ch.pos_a_y, req_ch.pos_b_x, req_ch.pos_b_y,
                              req_ch.mass_a, req_ch.mass_b, req_ch.radius_a,
                              req_ch.radius_b});
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{rsp_ch.force_north, rsp_ch.force_east, rsp_ch.overlap,
                              rsp_ch.saturated});
         if (csr_ch.valid && csr_ch.ready) sb.grav = csr_ch.data;
      end
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // response side
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_pair(pair_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.pos_a_x <= r.ax;
      req_ch.pos_a_y <= r.ay;
      req_ch.pos_b_x <= r.bx;
      req_ch.pos_b_y <= r.by;
      req_ch.mass_a <= r.ma;
      req_ch.mass_b <= r.mb;
      req_ch.radius_a <= r.ra;
      req_ch.radius_b <= r.rb;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (sb.expected_forces.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_grav(logic [MASS_W-1:0] g);
      csr_ch.valid <= 1;
      csr_ch.data <= g;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 0;
   endtask

   function automatic logic [31:0] scaled(int lo_shift);
      return $urandom >> $urandom_range(31, lo_shift);
   endfunction

   function automatic pair_type random_pair();
      pair_type r;
      int       kind;
      kind = $urandom_range(9);
      r.ax = $urandom; r.ay = $urandom; r.bx = $urandom; r.by = $urandom;
      r.ma = $urandom; r.mb = $urandom; r.ra = $urandom; r.rb = $urandom;
      if (kind >= 1 && kind <= 5) begin
         // nearby pairs with small radii, masses of any scale
         r.bx = r.ax + $signed(scaled(0));
         r.by = r.ay - $signed(scaled(0));
         r.ra = scaled(8);
         r.rb = scaled(8);
         r.ma = scaled(0);
         r.mb = scaled(0);
      end else if (kind == 6) begin
         r.bx = r.ax;
         r.by = r.ay;
         if ($urandom_range(1)) begin
            r.ra = 0;
            r.rb = 0;
         end
      end else if (kind == 7) begin
         r.bx = r.ax + $signed(scaled(16));
         r.by = r.ay + $signed(scaled(16));
      end else if (kind == 8) begin
         r.bx = r.ax + $signed(scaled(24));
         r.by = r.ay + $signed(scaled(24));
         r.ra = 0;
         r.rb = 0;
      end
      return r;
   endfunction

   task automatic run_directed();
      pair_type r;
      localparam logic [31:0] MX = 32'hFFFF_FFFF;
      localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
      localparam logic [31:0] SMIN = 32'h8000_0000;
      send_pair('{0, 0, 0, 0, 0, 0, 0, 0});
      send_pair('{0, 0, 0, 0, MX, MX, 0, 0});
      send_pair('{0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0, 0});
      send_pair('{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0});
      send_pair('{0, 0, -32'sh10000, 0, 32'h10000, 32'h10000, 0, 0});
      send_pair('{0, 0, 0, -32'sh10000, 32'h10000, 32'h10000, 0, 0});
      send_pair('{SMIN, SMIN, SMAX, SMAX, MX, MX, 0, 0});
      send_pair('{SMAX, SMAX, SMIN, SMIN, MX, MX, 0, 0});
      send_pair('{SMIN, SMAX, SMAX, SMIN, 1, 1, 0, 0});
      send_pair('{0, 0, 1, 0, MX, MX, 0, 0});
      send_pair('{0, 0, -1, -1, MX, MX, 0, 0});
      send_pair('{0, 0, 32'h30000, 32'h40000, 32'h20000, 32'h30000, 32'h20000, 32'h30000});
      send_pair('{0, 0, 32'h30000, 32'h40000, 32'h20000, 32'h30000, 32'h20000, 32'h30001});
      send_pair('{0, 0, 32'h30000, 32'h40000, 32'h20000, 32'h30000, MX, MX});
      send_pair('{5, 5, 5, 5, 32'h10000, 32'h10000, 0, 1});
      send_pair('{5, 5, 5, 5, 32'h10000, 32'h10000, 0, 0});
      send_pair('{0, 0, 1, 1, 0, MX, 0, 0});
      send_pair('{SMIN, 0, SMAX, 0, MX, MX, MX, MX});
      send_pair('{0, 0, 32'h100, -32'sh100, MX, 32'h1000, 0, 0});
      r = random_pair();
      send_pair(r);
   endtask

   initial begin
      logic [MASS_W-1:0] grav_set[4];
      int                send_mix[4];
      int                stall_mix[4];
      grav_set = '{GRAV_RESET, 32'hFFFF_FFFF, 32'd0, 32'd0};
      send_mix = '{0, 49, 0, 36};
      stall_mix = '{0, 0, 49, 36};
      grav_set[3] = $urandom;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_grav(grav_set[ph]);
         send_idle_pct = send_mix[ph];
         stall_pct = stall_mix[ph];
         if (ph == 0) run_directed();
         if (ph == 2) begin
            // long response hold-off so the pipeline fills and backs up
            write_grav(32'h0001_8000);
            hold_cycles = 300;
         end
         for (int i = 0; i < 120; i++) send_pair(random_pair());
         drain();
      end
      $display("covered %0d results: %0d overlaps, %0d clamped, 4 constants, 4 idle mixes",
               sb.checked, sb.overlaps, sb.clamps);
      if (sb.errors == 0 && sb.expected_forces.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
